// ----- sv/lnf_pkg.sv -----
// Shared widths, types and table-building functions for the logistic neuron.
package lnf_pkg;

  localparam int ACC_W = 48;
  localparam int PROD_W = 33;
  localparam int PIX_W = 16;
  localparam int WGT_W = 16;
  localparam int BIAS_W = 24;
  localparam int P_W = 16;
  localparam int Z_W = 20;
  localparam int FRAC_W = 20;
  localparam int Q_SHIFT = 15;

  localparam int DEF_MAX_ELEMENTS = 65536;
  localparam int DEF_SIG_ENTRIES = 256;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [P_W-1:0] probability;
    logic           is_positive;
  } res_t;

  typedef struct packed {
    logic [P_W-1:0] y0;
    logic [P_W-1:0] y1;
  } knot_row_t;

  // Restoring division, used only while the table constants are built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Returns e^(-a / 65536) in Q0.30 for 0 <= a <= 2^19.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] r;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    r = a << 6;
    t2 = (r * r) >> 30;
    t3 = (t2 * r) >> 30;
    t4 = (t3 * r) >> 30;
    e = Q30_ONE - r + (t2 >> 1) - t3 / 6 + t4 / 24;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (Q30_ONE >> 1)) >> 30;
    end
    return e;
  endfunction

  // Sigmoid value at knot k of a table with n segments over [-8, 8].
  function automatic logic [P_W-1:0] knot_value(input int k, input int n);
    logic signed [63:0] x;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] p;
    x = -64'sd524288 + $signed(udiv64(64'(k) << 20, 64'(n)));
    a = (x < 0) ? 64'(-x) : 64'(x);
    if (a > 64'd524288) begin
      a = 64'd524288;
    end
    e = exp_neg_q30(a);
    den = Q30_ONE + e;
    num = (x >= 0) ? Q30_ONE : e;
    p = udiv64((num << 16) + (den >> 1), den);
    if (p > 64'd65535) begin
      p = 64'd65535;
    end
    return p[P_W-1:0];
  endfunction

endpackage

// ----- sv/lnf_fifo.sv -----
// Small register queue with push/full and pop/empty handshakes.
module lnf_fifo #(
  parameter int WIDTH = $bits(lnf_pkg::res_t),
  parameter int DEPTH = lnf_pkg::OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import lnf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/lnf_front.sv -----
// Front end: accepts feature transactions, multiplies and accumulates, pushes finished sums out on mid_push.
module lnf_front #(
  parameter int MAX_ELEMENTS = lnf_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [lnf_pkg::PIX_W-1:0]          in_pixel,
  input  logic signed [lnf_pkg::WGT_W-1:0]   in_weight,
  input  logic                               in_last,
  output logic                               mid_push,
  output logic signed [lnf_pkg::ACC_W-1:0]   mid_data,
  input  logic                               mid_full
);
  import lnf_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum;
  logic                     accept;
  logic                     take;

  assign in_full = s1_valid_r && s1_last_r && mid_full;
  assign accept = in_push && !in_full;
  assign take = (cnt_r < CNT_W'(MAX_ELEMENTS));
  assign prod = $signed({1'b0, in_pixel}) * in_weight;
  assign sum = acc_r + ACC_W'(prod_r);
  assign mid_push = s1_valid_r && s1_last_r && !mid_full;
  assign mid_data = sum;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_last) begin
      cnt_nxt = '0;
    end else if (take) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      if (!in_full) begin
        s1_valid_r <= accept;
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (s1_valid_r && !in_full) begin
        acc_r <= s1_last_r ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= take ? prod : '0;
      s1_last_r <= in_last;
    end
  end

endmodule

// ----- sv/lnf_back.sv -----
// Back end: adds the bias, clamps, and interpolates the sigmoid from a knot table.
module lnf_back #(
  parameter int SIGMOID_TABLE_ENTRIES = lnf_pkg::DEF_SIG_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic signed [lnf_pkg::BIAS_W-1:0]  cfg_data,
  input  logic                               mid_empty,
  input  logic signed [lnf_pkg::ACC_W-1:0]   mid_data,
  output logic                               mid_pop,
  output logic                               res_push,
  output lnf_pkg::res_t                      res_data,
  input  logic                               res_full
);
  import lnf_pkg::*;

  localparam int IDX_W = $clog2(SIGMOID_TABLE_ENTRIES);
  localparam int POS_W = FRAC_W + IDX_W;
  localparam int Q_W = ACC_W - Q_SHIFT;
  localparam int ZS_W = Q_W + 1;
  localparam int MP_W = P_W + FRAC_W;
  localparam logic [POS_W-1:0] N_MUL = POS_W'(SIGMOID_TABLE_ENTRIES);
  localparam logic signed [ZS_W-1:0] Z_LO = -(ZS_W'(1) <<< (Z_W - 1));
  localparam logic signed [ZS_W-1:0] Z_HI = (ZS_W'(1) <<< (Z_W - 1)) - 1;

  knot_row_t knot_rom [SIGMOID_TABLE_ENTRIES];

  for (genvar k = 0; k < SIGMOID_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [P_W-1:0] Y0 = knot_value(k, SIGMOID_TABLE_ENTRIES);
    localparam logic [P_W-1:0] Y1 = knot_value(k + 1, SIGMOID_TABLE_ENTRIES);
    assign knot_rom[k] = '{y0: Y0, y1: Y1};
  end

  logic signed [BIAS_W-1:0] bias_r;
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     adv;

  logic signed [Q_W-1:0]    q;
  logic signed [ZS_W-1:0]   z;
  logic signed [ZS_W-1:0]   z_cl;
  logic [Z_W-1:0]           zoff_r;

  logic [POS_W-1:0]         pos;
  logic [IDX_W-1:0]         idx_r;
  logic [FRAC_W-1:0]        f2_r;

  knot_row_t                row_r;
  logic [FRAC_W-1:0]        f3_r;

  logic signed [P_W:0]      d;
  logic [P_W-1:0]           mag;
  logic [P_W-1:0]           y0_r;
  logic                     neg_r;
  logic [MP_W-1:0]          mp_r;

  logic [MP_W-1:0]          rounded;
  logic [P_W-1:0]           step;
  logic signed [P_W+1:0]    p_s;
  logic [P_W-1:0]           p;

  assign adv = !(v4_r && res_full);
  assign mid_pop = adv && !mid_empty;

  assign q = Q_W'(mid_data >>> Q_SHIFT);
  assign z = ZS_W'(q) + ZS_W'(bias_r);
  always_comb begin
    z_cl = z;
    if (z < Z_LO) begin
      z_cl = Z_LO;
    end else if (z > Z_HI) begin
      z_cl = Z_HI;
    end
  end

  assign pos = POS_W'(zoff_r) * N_MUL;

  assign d = $signed({1'b0, row_r.y1}) - $signed({1'b0, row_r.y0});
  assign mag = d[P_W] ? P_W'(-d) : d[P_W-1:0];

  assign rounded = mp_r + (MP_W'(1) << (FRAC_W - 1));
  assign step = rounded[MP_W-1:FRAC_W];
  assign p_s = neg_r ? ($signed({2'b00, y0_r}) - $signed({2'b00, step}))
                     : ($signed({2'b00, y0_r}) + $signed({2'b00, step}));
  always_comb begin
    p = p_s[P_W-1:0];
    if (p_s < 0) begin
      p = '0;
    end else if (p_s[P_W]) begin
      p = '1;
    end
  end

  assign res_push = v4_r && !res_full;
  assign res_data = '{probability: p, is_positive: p[P_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bias_r <= cfg_data;
      end
      if (adv) begin
        v1_r <= !mid_empty;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zoff_r <= Z_W'(z_cl - Z_LO);
      idx_r <= pos[POS_W-1:FRAC_W];
      f2_r <= pos[FRAC_W-1:0];
      row_r <= knot_rom[idx_r];
      f3_r <= f2_r;
      y0_r <= row_r.y0;
      neg_r <= d[P_W];
      mp_r <= mag * f3_r;
    end
  end

endmodule

// ----- sv/logistic_neuron_forward.sv -----
// Top level of the logistic neuron: front end, sum queue, back end and result queue.
//
// Feature transactions enter on in_push/in_full: one pixel, its weight and a last flag.
// A transaction is taken at a rising edge with in_push high and in_full low. One
// transaction is taken per cycle while in_full stays low; the multiply-accumulate stage sets that rate.
// Each transaction with in_last set produces one result; the sum of the vector is
// handed through a two-entry queue to the sigmoid pipeline, so both parts stall apart.
// Results leave on out_empty/out_pop: the oldest result sits on out_probability and
// out_is_positive while out_empty is low and is taken at an edge with out_pop high.
// After its last transaction is taken, a result passes one front stage, the sum queue,
// four back stages and the result queue before it becomes visible.
// If the receiver stops popping, the two-entry result queue fills, the sigmoid
// pipeline holds, the sum queue fills, and in_full rises once a last transaction
// can go no further; feature transactions without in_last keep flowing meanwhile.
// cfg_we writes cfg_data to the signed Q8.16 bias; write it only while idle.
// Synchronous reset clears the accumulator, element count, bias and both queues.
module logistic_neuron_forward #(
  parameter int MAX_ELEMENTS = lnf_pkg::DEF_MAX_ELEMENTS,
  parameter int SIGMOID_TABLE_ENTRIES = lnf_pkg::DEF_SIG_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [lnf_pkg::PIX_W-1:0]          in_pixel,
  input  logic signed [lnf_pkg::WGT_W-1:0]   in_weight,
  input  logic                               in_last,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [lnf_pkg::P_W-1:0]            out_probability,
  output logic                               out_is_positive,
  input  logic                               cfg_we,
  input  logic signed [lnf_pkg::BIAS_W-1:0]  cfg_data
);
  import lnf_pkg::*;

  logic                    mid_push;
  logic                    mid_full;
  logic signed [ACC_W-1:0] mid_in;
  logic                    mid_pop;
  logic                    mid_empty;
  logic [ACC_W-1:0]        mid_out;
  logic                    res_push;
  logic                    res_full;
  res_t                    res_in;
  res_t                    res_out;

  lnf_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_pixel (in_pixel),
    .in_weight(in_weight),
    .in_last  (in_last),
    .mid_push (mid_push),
    .mid_data (mid_in),
    .mid_full (mid_full)
  );

  lnf_fifo #(
    .WIDTH(ACC_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mid_push),
    .push_data(mid_in),
    .full     (mid_full),
    .pop      (mid_pop),
    .pop_data (mid_out),
    .empty    (mid_empty)
  );

  lnf_back #(
    .SIGMOID_TABLE_ENTRIES(SIGMOID_TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .mid_empty(mid_empty),
    .mid_data ($signed(mid_out)),
    .mid_pop  (mid_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  lnf_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (res_out),
    .empty    (out_empty)
  );

  assign out_probability = res_out.probability;
  assign out_is_positive = res_out.is_positive;

endmodule

// ----- tb/logistic_neuron_forward_tb.sv -----
// Self-checking testbench for the logistic neuron: feature streams, bias settings and stalls.
`timescale 1ns / 100ps

module logistic_neuron_forward_tb;

  localparam int SIG_N = lnf_pkg::DEF_SIG_ENTRIES;
  localparam int MAX_FEATURES = lnf_pkg::DEF_MAX_ELEMENTS;
  localparam longint Z_LO = -524288;
  localparam longint Z_HI = 524287;
  localparam longint ONE_Q30 = 64'd1 << 30;
  localparam int DRAIN_PAD = 12;

  logic                                clk;
  logic                                rst_n;
  logic                                in_push;
  logic                                in_full;
  logic [lnf_pkg::PIX_W-1:0]           in_pixel;
  logic signed [lnf_pkg::WGT_W-1:0]    in_weight;
  logic                                in_last;
  logic                                out_empty;
  logic                                out_pop;
  logic [lnf_pkg::P_W-1:0]             out_probability;
  logic                                out_is_positive;
  logic                                cfg_we;
  logic signed [lnf_pkg::BIAS_W-1:0]   cfg_data;

  lnf_pkg::res_t pending_probs[$];
  longint        knot_tbl[0:SIG_N];
  longint        acc_sum;
  int            feat_count;
  longint        bias_val;
  int            in_idle_pct;
  int            out_idle_pct;
  int            errors;
  int            features_sent;
  int            vectors_sent;
  int            results_seen;
  int            bias_writes;

  logistic_neuron_forward u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel       (in_pixel),
    .in_weight      (in_weight),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_probability(out_probability),
    .out_is_positive(out_is_positive),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint exp_neg(longint a);
    longint r;
    longint t2;
    longint t3;
    longint t4;
    longint e;
    r = a << 6;
    t2 = (r * r) >> 30;
    t3 = (t2 * r) >> 30;
    t4 = (t3 * r) >> 30;
    e = ONE_Q30 - r + (t2 >> 1) - t3 / 6 + t4 / 24;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (ONE_Q30 >> 1)) >> 30;
    end
    return e;
  endfunction

  function automatic longint sigmoid_knot(longint k);
    longint x;
    longint a;
    longint e;
    longint den;
    longint num;
    longint p;
    x = Z_LO + (k * 1048576) / SIG_N;
    a = (x < 0) ? -x : x;
    if (a > 524288) begin
      a = 524288;
    end
    e = exp_neg(a);
    den = ONE_Q30 + e;
    num = (x >= 0) ? ONE_Q30 : e;
    p = ((num << 16) + (den >> 1)) / den;
    if (p > 65535) begin
      p = 65535;
    end
    return p;
  endfunction

  function automatic lnf_pkg::res_t neuron_output(longint sum, longint b);
    lnf_pkg::res_t res;
    longint z;
    longint pos;
    longint seg;
    longint f;
    longint y0;
    longint d;
    longint p;
    z = (sum >>> 15) + b;
    if (z < Z_LO) begin
      z = Z_LO;
    end
    if (z > Z_HI) begin
      z = Z_HI;
    end
    pos = (z - Z_LO) * SIG_N;
    seg = pos >> 20;
    f = pos & 64'hFFFFF;
    y0 = knot_tbl[seg];
    d = knot_tbl[seg + 1] - y0;
    if (d >= 0) begin
      p = y0 + ((d * f + 64'h80000) >> 20);
    end else begin
      p = y0 - (((-d) * f + 64'h80000) >> 20);
    end
    if (p < 0) begin
      p = 0;
    end
    if (p > 65535) begin
      p = 65535;
    end
    res.probability = p[15:0];
    res.is_positive = (p >= 32768);
    return res;
  endfunction

  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    lnf_pkg::res_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_probs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: probability %0d is_positive %0d", $time,
                 out_probability, out_is_positive);
      end else begin
        want = pending_probs.pop_front();
        if (out_probability !== want.probability) begin
          errors++;
          $display("%0t: probability mismatch: expected %0d actual %0d", $time,
                   want.probability, out_probability);
        end
        if (out_is_positive !== want.is_positive) begin
          errors++;
          $display("%0t: is_positive mismatch: expected %0d actual %0d", $time,
                   want.is_positive, out_is_positive);
        end
      end
    end
  end

  // Called right after a falling edge; returns right after a falling edge, once the transaction has been taken.
  task automatic send_feature(logic [15:0] pix, logic signed [15:0] wgt, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_pixel <= pix;
    in_weight <= wgt;
    in_last <= last;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    features_sent++;
    if (feat_count < MAX_FEATURES) begin
      acc_sum += longint'(pix) * longint'(wgt);
      feat_count++;
    end
    if (last) begin
      pending_probs.push_back(neuron_output(acc_sum, bias_val));
      acc_sum = 0;
      feat_count = 0;
      vectors_sent++;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_probs.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_bias(logic signed [23:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    bias_val = longint'(value);
    bias_writes++;
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return -16'sd32768;
      2, 3: return 16'($signed(8'($urandom)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_bias();
    case ($urandom_range(3))
      0: return 24'($urandom);
      default: return 24'($signed(19'($urandom)));
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++) begin
      send_feature(pick_pixel(), pick_weight(), i == len - 1);
    end
  endtask

  task automatic test_directed_extremes();
    send_feature(16'd0, 16'sd0, 1'b1);
    send_feature(16'hFFFF, 16'sh7FFF, 1'b1);
    send_feature(16'hFFFF, -16'sd32768, 1'b1);
    send_feature(16'd0, -16'sd32768, 1'b1);
    send_feature(16'hFFFF, -16'sd1, 1'b1);
    send_feature(16'd1, 16'sd1, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_feature(16'hFFFF, 16'sh7FFF, i == 5);
    end
    for (int i = 0; i < 6; i++) begin
      send_feature(16'hFFFF, -16'sd32768, i == 5);
    end
    write_bias(24'sh7FFFFF);
    send_feature(16'h8000, -16'sd32768, 1'b1);
    send_feature(16'h5555, 16'shAAAA, 1'b1);
    write_bias(-24'sd8388608);
    send_feature(16'hFFFF, 16'sh7FFF, 1'b1);
    send_feature(16'hAAAA, 16'sh5555, 1'b1);
    write_bias(24'sd0);
  endtask

  task automatic test_bias_settings();
    logic signed [23:0] settings[6];
    settings = '{24'sd1, -24'sd1, 24'sd65536, -24'sd524288, 24'sd524287, 24'sh555555};
    foreach (settings[i]) begin
      write_bias(settings[i]);
      for (int v = 0; v < 3; v++) begin
        send_vector($urandom_range(1, 4));
      end
    end
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    for (int phase = 0; phase < 5; phase++) begin
      write_bias(pick_bias());
      in_idle_pct = (phase == 2) ? 0 : 28;
      out_idle_pct = (phase == 2) ? 0 : 28;
      sent = 0;
      while (sent < 300) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_vector(len);
        sent += len;
        if ($urandom_range(39) == 0) begin
          drain_results();
        end
      end
    end
    in_idle_pct = 28;
    out_idle_pct = 28;
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_pixel = '0;
    in_weight = '0;
    in_last = 1'b0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_idle_pct = 28;
    out_idle_pct = 28;
    errors = 0;
    features_sent = 0;
    vectors_sent = 0;
    results_seen = 0;
    bias_writes = 0;
    acc_sum = 0;
    feat_count = 0;
    bias_val = 0;
    for (int k = 0; k <= SIG_N; k++) begin
      knot_tbl[k] = sigmoid_knot(k);
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_bias_settings();
    test_random_traffic();
    drain_results();

    $display("Sent %0d feature transactions in %0d vectors across %0d bias writes.",
             features_sent, vectors_sent, bias_writes);
    $display("Checked %0d results, with extreme sums and idle and busy stretches; %0d mismatches.",
             results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- logistic_neuron_forward.f -----
sv/lnf_pkg.sv
sv/lnf_fifo.sv
sv/lnf_front.sv
sv/lnf_back.sv
sv/logistic_neuron_forward.sv
tb/logistic_neuron_forward_tb.sv
